/* hdl/rvdec_pkg.sv */
// Package with the code types, opcodes and control bundle of the RV64IM control decoder.
package rvdec_pkg;

  typedef enum logic [1:0] {
    BUBBLE_NONE    = 2'd0,
    BUBBLE_NOP     = 2'd1,
    BUBBLE_FP      = 2'd2,
    BUBBLE_UNKNOWN = 2'd3
  } bubble_kind_t;

  typedef enum logic [1:0] {
    SRC_A_RS1  = 2'd0,
    SRC_A_ZERO = 2'd1,
    SRC_A_PC   = 2'd2
  } src_a_t;

  typedef enum logic [1:0] {
    WB_NONE = 2'd0,
    WB_ALU  = 2'd1,
    WB_MEM  = 2'd2,
    WB_PC4  = 2'd3
  } wb_src_t;

  typedef enum logic [4:0] {
    ALU_NONE   = 5'd0,
    ALU_ADD    = 5'd1,
    ALU_SUB    = 5'd2,
    ALU_MUL    = 5'd3,
    ALU_MULH   = 5'd4,
    ALU_MULHSU = 5'd5,
    ALU_MULHU  = 5'd6,
    ALU_DIV    = 5'd7,
    ALU_DIVU   = 5'd8,
    ALU_REM    = 5'd9,
    ALU_REMU   = 5'd10,
    ALU_SLL    = 5'd11,
    ALU_SLT    = 5'd12,
    ALU_SLTU   = 5'd13,
    ALU_XOR    = 5'd14,
    ALU_SRL    = 5'd15,
    ALU_SRA    = 5'd16,
    ALU_OR     = 5'd17,
    ALU_AND    = 5'd18
  } alu_op_t;

  typedef enum logic [3:0] {
    BR_NONE = 4'd0,
    BR_BEQ  = 4'd1,
    BR_BNE  = 4'd2,
    BR_BLT  = 4'd3,
    BR_BGE  = 4'd4,
    BR_BLTU = 4'd5,
    BR_BGEU = 4'd6,
    BR_JAL  = 4'd7,
    BR_JALR = 4'd8
  } branch_kind_t;

  typedef enum logic [2:0] {
    LD_NONE = 3'd0,
    LD_B    = 3'd1,
    LD_H    = 3'd2,
    LD_W    = 3'd3,
    LD_D    = 3'd4,
    LD_BU   = 3'd5,
    LD_HU   = 3'd6,
    LD_WU   = 3'd7
  } load_kind_t;

  typedef enum logic [2:0] {
    ST_NONE = 3'd0,
    ST_B    = 3'd1,
    ST_H    = 3'd2,
    ST_W    = 3'd3,
    ST_D    = 3'd4
  } store_kind_t;

  localparam logic [31:0] NOP_ZERO = 32'h0000_0000;
  localparam logic [31:0] NOP_ADDI = 32'h0000_0013;
  localparam logic [31:0] NOP_ADD  = 32'h0000_0033;

  localparam logic [6:0] OPC_OP      = 7'b0110011;
  localparam logic [6:0] OPC_LOAD    = 7'b0000011;
  localparam logic [6:0] OPC_STORE   = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH  = 7'b1100011;
  localparam logic [6:0] OPC_OP_IMM  = 7'b0010011;
  localparam logic [6:0] OPC_LUI     = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC   = 7'b0010111;
  localparam logic [6:0] OPC_JAL     = 7'b1101111;
  localparam logic [6:0] OPC_JALR    = 7'b1100111;
  localparam logic [6:0] OPC_ODD     = 7'b0000001;
  localparam logic [6:0] OPC_LOAD_FP = 7'b0000111;
  localparam logic [6:0] OPC_STORE_FP = 7'b0100111;
  localparam logic [6:0] OPC_OP_FP   = 7'b1010011;
  localparam logic [6:0] OPC_FMADD   = 7'b1000011;
  localparam logic [6:0] OPC_FMSUB   = 7'b1000111;
  localparam logic [6:0] OPC_FNMSUB  = 7'b1001011;
  localparam logic [6:0] OPC_FNMADD  = 7'b1001111;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_MEXT = 7'b0000001;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [5:0] F6_SRL  = 6'b000000;
  localparam logic [5:0] F6_SRA  = 6'b010000;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SR  = 3'd5;

  typedef struct packed {
    bubble_kind_t bubble_kind;
    logic         rd_wen;
    logic         dmem_ren;
    logic         dmem_wen;
    logic         is_branch;
    src_a_t       src_a_select;
    logic         src_b_immediate;
    wb_src_t      writeback_source;
    alu_op_t      alu_operation;
    branch_kind_t branch_kind;
    load_kind_t   load_kind;
    store_kind_t  store_kind;
  } ctrl_t;

endpackage

/* hdl/rv64im_control_decoder.sv */
// Top level of the RV64IM control decoder: input register, decode logic and result register.
// The decoder takes one instruction word in every cycle in which start is high and busy is
// low; busy is high only while reset is held. The word is captured in an input register,
// decoded by one level of combinational logic and captured again in the result register,
// so each result is shown with out_valid high for exactly one cycle, in the same order
// as the words came in. The receiver cannot stall the block and must take each result in
// the cycle it is shown; the throughput is one word per cycle.
module rv64im_control_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  output logic [1:0]  out_bubble_kind,
  output logic        out_rd_wen,
  output logic        out_dmem_ren,
  output logic        out_dmem_wen,
  output logic        out_is_branch,
  output logic [1:0]  out_src_a_select,
  output logic        out_src_b_immediate,
  output logic [1:0]  out_writeback_source,
  output logic [4:0]  out_alu_operation,
  output logic [3:0]  out_branch_kind,
  output logic [2:0]  out_load_kind,
  output logic [2:0]  out_store_kind
);
  import rvdec_pkg::*;

  logic        in_valid_r;
  logic        in_valid_nxt;
  logic [31:0] instr_r;
  logic        res_valid_r;
  ctrl_t       ctrl_nxt;
  ctrl_t       ctrl_r;

  assign busy         = ~rst_n;
  assign in_valid_nxt = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      res_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      instr_r <= in_instruction;
    end
    if (in_valid_r) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  rvdec_decode u_decode (
    .instruction (instr_r),
    .ctrl        (ctrl_nxt)
  );

  assign out_valid            = res_valid_r;
  assign out_bubble_kind      = ctrl_r.bubble_kind;
  assign out_rd_wen           = ctrl_r.rd_wen;
  assign out_dmem_ren         = ctrl_r.dmem_ren;
  assign out_dmem_wen         = ctrl_r.dmem_wen;
  assign out_is_branch        = ctrl_r.is_branch;
  assign out_src_a_select     = ctrl_r.src_a_select;
  assign out_src_b_immediate  = ctrl_r.src_b_immediate;
  assign out_writeback_source = ctrl_r.writeback_source;
  assign out_alu_operation    = ctrl_r.alu_operation;
  assign out_branch_kind      = ctrl_r.branch_kind;
  assign out_load_kind        = ctrl_r.load_kind;
  assign out_store_kind       = ctrl_r.store_kind;

endmodule

/* hdl/rvdec_decode.sv */
// Combinational decode of one instruction word into the pipeline control bundle.
module rvdec_decode (
  input  logic [31:0]   instruction,
  output rvdec_pkg::ctrl_t ctrl
);
  import rvdec_pkg::*;

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [5:0] f6;

  assign opc = instruction[6:0];
  assign f3  = instruction[14:12];
  assign f7  = instruction[31:25];
  assign f6  = instruction[31:26];

  function automatic alu_op_t base_op(input logic [2:0] sel);
    case (sel)
      3'd0:    base_op = ALU_ADD;
      3'd1:    base_op = ALU_SLL;
      3'd2:    base_op = ALU_SLT;
      3'd3:    base_op = ALU_SLTU;
      3'd4:    base_op = ALU_XOR;
      3'd5:    base_op = ALU_SRL;
      3'd6:    base_op = ALU_OR;
      default: base_op = ALU_AND;
    endcase
  endfunction

  function automatic alu_op_t mext_op(input logic [2:0] sel);
    case (sel)
      3'd0:    mext_op = ALU_MUL;
      3'd1:    mext_op = ALU_MULH;
      3'd2:    mext_op = ALU_MULHSU;
      3'd3:    mext_op = ALU_MULHU;
      3'd4:    mext_op = ALU_DIV;
      3'd5:    mext_op = ALU_DIVU;
      3'd6:    mext_op = ALU_REM;
      default: mext_op = ALU_REMU;
    endcase
  endfunction

  function automatic alu_op_t branch_alu(input logic [2:0] sel);
    case (sel)
      3'd0, 3'd1: branch_alu = ALU_SUB;
      3'd4, 3'd5: branch_alu = ALU_SLT;
      3'd6, 3'd7: branch_alu = ALU_SLTU;
      default:    branch_alu = ALU_NONE;
    endcase
  endfunction

  function automatic branch_kind_t branch_sel(input logic [2:0] sel);
    case (sel)
      3'd0:    branch_sel = BR_BEQ;
      3'd1:    branch_sel = BR_BNE;
      3'd4:    branch_sel = BR_BLT;
      3'd5:    branch_sel = BR_BGE;
      3'd6:    branch_sel = BR_BLTU;
      3'd7:    branch_sel = BR_BGEU;
      default: branch_sel = BR_NONE;
    endcase
  endfunction

  function automatic load_kind_t load_sel(input logic [2:0] sel);
    case (sel)
      3'd0:    load_sel = LD_B;
      3'd1:    load_sel = LD_H;
      3'd2:    load_sel = LD_W;
      3'd3:    load_sel = LD_D;
      3'd4:    load_sel = LD_BU;
      3'd5:    load_sel = LD_HU;
      3'd6:    load_sel = LD_WU;
      default: load_sel = LD_NONE;
    endcase
  endfunction

  function automatic store_kind_t store_sel(input logic [2:0] sel);
    case (sel)
      3'd0:    store_sel = ST_B;
      3'd1:    store_sel = ST_H;
      3'd2:    store_sel = ST_W;
      3'd3:    store_sel = ST_D;
      default: store_sel = ST_NONE;
    endcase
  endfunction

  always_comb begin
    ctrl = '0;
    if (instruction == NOP_ZERO || instruction == NOP_ADDI || instruction == NOP_ADD) begin
      ctrl.bubble_kind = BUBBLE_NOP;
      if (instruction != NOP_ZERO) begin
        ctrl.alu_operation = ALU_ADD;
      end
      if (instruction == NOP_ADDI) begin
        ctrl.src_b_immediate = 1'b1;
      end
    end else if (opc == OPC_LOAD_FP || opc == OPC_STORE_FP || opc == OPC_OP_FP ||
                 opc == OPC_FMADD || opc == OPC_FMSUB || opc == OPC_FNMSUB ||
                 opc == OPC_FNMADD) begin
      ctrl.bubble_kind = BUBBLE_FP;
    end else begin
      case (opc)
        OPC_OP: begin
          ctrl.rd_wen           = 1'b1;
          ctrl.writeback_source = WB_ALU;
          if (f7 == F7_BASE) begin
            ctrl.alu_operation = base_op(f3);
          end else if (f7 == F7_MEXT) begin
            ctrl.alu_operation = mext_op(f3);
          end else if (f7 == F7_ALT && f3 == F3_ADD) begin
            ctrl.alu_operation = ALU_SUB;
          end else if (f7 == F7_ALT && f3 == F3_SR) begin
            ctrl.alu_operation = ALU_SRA;
          end
        end
        OPC_LOAD: begin
          ctrl.src_b_immediate  = 1'b1;
          ctrl.writeback_source = WB_MEM;
          ctrl.rd_wen           = 1'b1;
          ctrl.dmem_ren         = 1'b1;
          ctrl.alu_operation    = ALU_ADD;
          ctrl.load_kind        = load_sel(f3);
        end
        OPC_STORE: begin
          ctrl.src_b_immediate = 1'b1;
          ctrl.dmem_wen        = 1'b1;
          ctrl.alu_operation   = ALU_ADD;
          ctrl.store_kind      = store_sel(f3);
        end
        OPC_BRANCH: begin
          ctrl.is_branch     = 1'b1;
          ctrl.alu_operation = branch_alu(f3);
          ctrl.branch_kind   = branch_sel(f3);
        end
        OPC_OP_IMM: begin
          ctrl.src_b_immediate  = 1'b1;
          ctrl.rd_wen           = 1'b1;
          ctrl.writeback_source = WB_ALU;
          if (f3 == F3_SR) begin
            if (f6 == F6_SRL) begin
              ctrl.alu_operation = ALU_SRL;
            end else if (f6 == F6_SRA) begin
              ctrl.alu_operation = ALU_SRA;
            end
          end else begin
            ctrl.alu_operation = base_op(f3);
          end
        end
        OPC_LUI: begin
          ctrl.src_b_immediate  = 1'b1;
          ctrl.rd_wen           = 1'b1;
          ctrl.writeback_source = WB_ALU;
          ctrl.src_a_select     = SRC_A_ZERO;
          ctrl.alu_operation    = ALU_ADD;
        end
        OPC_AUIPC: begin
          ctrl.src_b_immediate  = 1'b1;
          ctrl.rd_wen           = 1'b1;
          ctrl.writeback_source = WB_ALU;
          ctrl.src_a_select     = SRC_A_PC;
          ctrl.alu_operation    = ALU_ADD;
        end
        OPC_JAL: begin
          ctrl.rd_wen           = 1'b1;
          ctrl.is_branch        = 1'b1;
          ctrl.writeback_source = WB_PC4;
          ctrl.src_a_select     = SRC_A_PC;
          ctrl.src_b_immediate  = 1'b1;
          ctrl.alu_operation    = ALU_ADD;
          ctrl.branch_kind      = BR_JAL;
        end
        OPC_JALR: begin
          ctrl.src_b_immediate  = 1'b1;
          ctrl.rd_wen           = 1'b1;
          ctrl.is_branch        = 1'b1;
          ctrl.writeback_source = WB_PC4;
          ctrl.alu_operation    = ALU_ADD;
          ctrl.branch_kind      = BR_JALR;
        end
        OPC_ODD: begin
          ctrl.rd_wen           = 1'b1;
          ctrl.writeback_source = WB_ALU;
        end
        default: begin
          ctrl.bubble_kind = BUBBLE_UNKNOWN;
        end
      endcase
    end
  end

endmodule

/* hdl/rvdec_checker.sv */
// Port-level checker of the RV64IM control decoder and its bind to the top level.
module rvdec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_bubble_kind,
  input logic       out_rd_wen,
  input logic       out_dmem_ren,
  input logic       out_dmem_wen,
  input logic [1:0] out_writeback_source,
  input logic [4:0] out_alu_operation,
  input logic [3:0] out_branch_kind
);
  import rvdec_pkg::*;

  // Every result beat stems from an accepted beat, through the input and result registers.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result beat without a matching input beat");

  // Every accepted beat yields a result unless reset intervened.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start && !busy, 2) && $past(rst_n, 1)) |-> out_valid)
    else $error("input beat lost");

  // A rejected opcode carries no control at all.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_bubble_kind == BUBBLE_FP || out_bubble_kind == BUBBLE_UNKNOWN))
      |-> (!out_rd_wen && !out_dmem_ren && !out_dmem_wen &&
           out_alu_operation == ALU_NONE && out_branch_kind == BR_NONE))
    else $error("rejected opcode carries control");

  // A load always writes back memory data into a register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dmem_ren)
      |-> (out_rd_wen && out_writeback_source == WB_MEM && !out_dmem_wen))
    else $error("load with inconsistent write-back");

endmodule

bind rv64im_control_decoder rvdec_checker u_rvdec_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_bubble_kind      (out_bubble_kind),
  .out_rd_wen           (out_rd_wen),
  .out_dmem_ren         (out_dmem_ren),
  .out_dmem_wen         (out_dmem_wen),
  .out_writeback_source (out_writeback_source),
  .out_alu_operation    (out_alu_operation),
  .out_branch_kind      (out_branch_kind)
);

/* dv/testbench.sv */
// Self-checking testbench for the RV64IM control decoder: directed table, then random words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rvdec_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  localparam int WORD_COUNT = 1200;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT = 1000;
  localparam int DIRECTED_COUNT = 26;

  typedef struct {
    logic [31:0]  word;
    logic         typed;
    bubble_kind_t kind;
    alu_op_t      alu;
    logic         imm_b;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_instruction = '0;
  logic        out_valid;
  logic [1:0]  out_bubble_kind;
  logic        out_rd_wen;
  logic        out_dmem_ren;
  logic        out_dmem_wen;
  logic        out_is_branch;
  logic [1:0]  out_src_a_select;
  logic        out_src_b_immediate;
  logic [1:0]  out_writeback_source;
  logic [4:0]  out_alu_operation;
  logic [3:0]  out_branch_kind;
  logic [2:0]  out_load_kind;
  logic [2:0]  out_store_kind;

  ctrl_t word_controls = '0;
  logic  beat_taken = 1'b0;
  ctrl_t pending_controls [$];
  int    fault_count = 0;
  int    quiet_cycles = 0;

  alu_op_t base_ops [8] = '{ALU_ADD, ALU_SLL, ALU_SLT, ALU_SLTU,
                            ALU_XOR, ALU_SRL, ALU_OR, ALU_AND};
  alu_op_t branch_ops [8] = '{ALU_SUB, ALU_SUB, ALU_NONE, ALU_NONE,
                              ALU_SLT, ALU_SLT, ALU_SLTU, ALU_SLTU};
  branch_kind_t branch_kinds [8] = '{BR_BEQ, BR_BNE, BR_NONE, BR_NONE,
                                     BR_BLT, BR_BGE, BR_BLTU, BR_BGEU};
  load_kind_t load_kinds [8] = '{LD_B, LD_H, LD_W, LD_D, LD_BU, LD_HU, LD_WU, LD_NONE};
  store_kind_t store_kinds [8] = '{ST_B, ST_H, ST_W, ST_D,
                                   ST_NONE, ST_NONE, ST_NONE, ST_NONE};
  logic [6:0] real_opcodes [10] = '{OPC_OP, OPC_LOAD, OPC_STORE, OPC_BRANCH, OPC_OP_IMM,
                                    OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_ODD};
  logic [6:0] fp_opcodes [7] = '{OPC_LOAD_FP, OPC_STORE_FP, OPC_OP_FP, OPC_FMADD,
                                 OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD};
  logic [31:0] nop_words [3] = '{NOP_ZERO, NOP_ADDI, NOP_ADD};
  string field_names [12] = '{"bubble_kind", "rd_wen", "dmem_ren", "dmem_wen",
                              "is_branch", "src_a_select", "src_b_immediate",
                              "writeback_source", "alu_operation", "branch_kind",
                              "load_kind", "store_kind"};

  stim_row_t directed_rows [DIRECTED_COUNT] = '{
    '{NOP_ZERO, 1'b1, BUBBLE_NOP, ALU_NONE, 1'b0},
    '{NOP_ADDI, 1'b1, BUBBLE_NOP, ALU_ADD, 1'b1},
    '{NOP_ADD, 1'b1, BUBBLE_NOP, ALU_ADD, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, BUBBLE_UNKNOWN, ALU_NONE, 1'b0},
    '{{25'h1FF_FFFF, OPC_LOAD_FP}, 1'b1, BUBBLE_FP, ALU_NONE, 1'b0},
    '{{25'h000_0000, OPC_STORE_FP}, 1'b1, BUBBLE_FP, ALU_NONE, 1'b0},
    '{{25'h1FF_FFFF, OPC_OP_FP}, 1'b1, BUBBLE_FP, ALU_NONE, 1'b0},
    '{{25'h0AA_AAAA, OPC_FMADD}, 1'b1, BUBBLE_FP, ALU_NONE, 1'b0},
    '{{25'h155_5555, OPC_FMSUB}, 1'b1, BUBBLE_FP, ALU_NONE, 1'b0},
    '{{25'h1FF_FFFF, OPC_FNMSUB}, 1'b1, BUBBLE_FP, ALU_NONE, 1'b0},
    '{{25'h000_0001, OPC_FNMADD}, 1'b1, BUBBLE_FP, ALU_NONE, 1'b0},
    '{{F7_BASE, 10'h3FF, F3_ADD, 5'h1F, OPC_OP}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{F7_ALT, 10'h3FF, F3_ADD, 5'h1F, OPC_OP}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{F7_MEXT, 10'h3FF, 3'b111, 5'h1F, OPC_OP}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{F7_ALT, 10'h000, F3_SR, 5'h00, OPC_OP}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{7'h7F, 10'h3FF, 3'b111, 5'h1F, OPC_OP}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{F6_SRA, 6'h3F, 5'h1F, F3_SR, 5'h1F, OPC_OP_IMM}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{6'h3F, 6'h3F, 5'h1F, F3_SR, 5'h1F, OPC_OP_IMM}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{17'h1FFFF, 3'b111, 5'h1F, OPC_LOAD}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{17'h00000, 3'b100, 5'h00, OPC_STORE}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{17'h1FFFF, 3'b010, 5'h1F, OPC_BRANCH}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{25'h1FF_FFFF, OPC_LUI}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{25'h000_0000, OPC_AUIPC}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{25'h1FF_FFFF, OPC_JAL}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{25'h000_0000, OPC_JALR}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0},
    '{{25'h1FF_FFFF, OPC_ODD}, 1'b0, BUBBLE_NONE, ALU_NONE, 1'b0}
  };

  rv64im_control_decoder dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_instruction       (in_instruction),
    .out_valid            (out_valid),
    .out_bubble_kind      (out_bubble_kind),
    .out_rd_wen           (out_rd_wen),
    .out_dmem_ren         (out_dmem_ren),
    .out_dmem_wen         (out_dmem_wen),
    .out_is_branch        (out_is_branch),
    .out_src_a_select     (out_src_a_select),
    .out_src_b_immediate  (out_src_b_immediate),
    .out_writeback_source (out_writeback_source),
    .out_alu_operation    (out_alu_operation),
    .out_branch_kind      (out_branch_kind),
    .out_load_kind        (out_load_kind),
    .out_store_kind       (out_store_kind)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic ctrl_t decode_controls(input logic [31:0] w);
    ctrl_t      c;
    logic [6:0] opc;
    logic [6:0] f7;
    logic [5:0] f6;
    logic [2:0] f3;
    c = '0;
    opc = w[6:0];
    f7 = w[31:25];
    f6 = w[31:26];
    f3 = w[14:12];
    if (w == NOP_ZERO || w == NOP_ADDI || w == NOP_ADD) begin
      c.bubble_kind = BUBBLE_NOP;
      if (w != NOP_ZERO) c.alu_operation = ALU_ADD;
      if (w == NOP_ADDI) c.src_b_immediate = 1'b1;
    end else if (opc inside {OPC_LOAD_FP, OPC_STORE_FP, OPC_OP_FP, OPC_FMADD,
                             OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD}) begin
      c.bubble_kind = BUBBLE_FP;
    end else begin
      case (opc)
        OPC_OP: begin
          c.rd_wen = 1'b1;
          c.writeback_source = WB_ALU;
          if (f7 == F7_BASE) c.alu_operation = base_ops[f3];
          else if (f7 == F7_MEXT) c.alu_operation = alu_op_t'(ALU_MUL + f3);
          else if (f7 == F7_ALT && f3 == F3_ADD) c.alu_operation = ALU_SUB;
          else if (f7 == F7_ALT && f3 == F3_SR) c.alu_operation = ALU_SRA;
        end
        OPC_LOAD: begin
          c.src_b_immediate = 1'b1;
          c.writeback_source = WB_MEM;
          c.rd_wen = 1'b1;
          c.dmem_ren = 1'b1;
          c.alu_operation = ALU_ADD;
          c.load_kind = load_kinds[f3];
        end
        OPC_STORE: begin
          c.src_b_immediate = 1'b1;
          c.dmem_wen = 1'b1;
          c.alu_operation = ALU_ADD;
          c.store_kind = store_kinds[f3];
        end
        OPC_BRANCH: begin
          c.is_branch = 1'b1;
          c.alu_operation = branch_ops[f3];
          c.branch_kind = branch_kinds[f3];
        end
        OPC_OP_IMM: begin
          c.src_b_immediate = 1'b1;
          c.rd_wen = 1'b1;
          c.writeback_source = WB_ALU;
          if (f3 != F3_SR) c.alu_operation = base_ops[f3];
          else if (f6 == F6_SRL) c.alu_operation = ALU_SRL;
          else if (f6 == F6_SRA) c.alu_operation = ALU_SRA;
        end
        OPC_LUI, OPC_AUIPC: begin
          c.src_b_immediate = 1'b1;
          c.rd_wen = 1'b1;
          c.writeback_source = WB_ALU;
          c.src_a_select = (opc == OPC_LUI) ? SRC_A_ZERO : SRC_A_PC;
          c.alu_operation = ALU_ADD;
        end
        OPC_JAL: begin
          c.rd_wen = 1'b1;
          c.is_branch = 1'b1;
          c.writeback_source = WB_PC4;
          c.src_a_select = SRC_A_PC;
          c.src_b_immediate = 1'b1;
          c.alu_operation = ALU_ADD;
          c.branch_kind = BR_JAL;
        end
        OPC_JALR: begin
          c.src_b_immediate = 1'b1;
          c.rd_wen = 1'b1;
          c.is_branch = 1'b1;
          c.writeback_source = WB_PC4;
          c.alu_operation = ALU_ADD;
          c.branch_kind = BR_JALR;
        end
        OPC_ODD: begin
          c.rd_wen = 1'b1;
          c.writeback_source = WB_ALU;
        end
        default: c.bubble_kind = BUBBLE_UNKNOWN;
      endcase
    end
    return c;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          pick;
    w = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 6) return w;
    if (pick < 10) return nop_words[$urandom_range(0, 2)];
    if (pick < 16) begin
      w[6:0] = fp_opcodes[$urandom_range(0, 6)];
      return w;
    end
    w[6:0] = real_opcodes[$urandom_range(0, 9)];
    if (w[6:0] == OPC_OP) begin
      case ($urandom_range(0, 3))
        0: w[31:25] = F7_BASE;
        1: w[31:25] = F7_MEXT;
        2: w[31:25] = F7_ALT;
        default: ;
      endcase
    end
    if (w[6:0] == OPC_OP_IMM && $urandom_range(0, 2) == 0) begin
      w[14:12] = F3_SR;
      if ($urandom_range(0, 3) != 0) w[31:26] = $urandom_range(0, 1) ? F6_SRA : F6_SRL;
    end
    return w;
  endfunction

  function automatic void split_fields(input ctrl_t c, output logic [4:0] f [12]);
    f[0] = 5'(c.bubble_kind);
    f[1] = 5'(c.rd_wen);
    f[2] = 5'(c.dmem_ren);
    f[3] = 5'(c.dmem_wen);
    f[4] = 5'(c.is_branch);
    f[5] = 5'(c.src_a_select);
    f[6] = 5'(c.src_b_immediate);
    f[7] = 5'(c.writeback_source);
    f[8] = c.alu_operation;
    f[9] = 5'(c.branch_kind);
    f[10] = 5'(c.load_kind);
    f[11] = 5'(c.store_kind);
  endfunction

  task automatic compare_controls(input ctrl_t want, input ctrl_t got);
    logic [4:0] want_f [12];
    logic [4:0] got_f [12];
    split_fields(want, want_f);
    split_fields(got, got_f);
    for (int i = 0; i < 12; i++) begin
      if (got_f[i] !== want_f[i]) begin
        fault_count++;
        $error("%s: expected %0d, actual %0d", field_names[i], want_f[i], got_f[i]);
      end
    end
  endtask

  task automatic send_word(input logic [31:0] w, input ctrl_t want);
    start <= 1'b1;
    in_instruction <= w;
    word_controls <= want;
    do @(negedge clk); while (!beat_taken);
  endtask

  task automatic pause_input(input int cycles);
    start <= 1'b0;
    in_instruction <= $urandom;
    repeat (cycles) @(negedge clk);
  endtask

  always @(posedge clk) begin
    ctrl_t got;
    beat_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) pending_controls.push_back(word_controls);
    if (rst_n && out_valid) begin
      got = ctrl_t'({out_bubble_kind, out_rd_wen, out_dmem_ren, out_dmem_wen,
                     out_is_branch, out_src_a_select, out_src_b_immediate,
                     out_writeback_source, out_alu_operation, out_branch_kind,
                     out_load_kind, out_store_kind});
      if (pending_controls.size() == 0) begin
        fault_count++;
        $error("result beat with no instruction outstanding");
      end else begin
        compare_controls(pending_controls.pop_front(), got);
      end
    end
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ctrl_t row_controls;
    int    gap_odds;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        row_controls = '0;
        row_controls.bubble_kind = directed_rows[i].kind;
        row_controls.alu_operation = directed_rows[i].alu;
        row_controls.src_b_immediate = directed_rows[i].imm_b;
      end else begin
        row_controls = decode_controls(directed_rows[i].word);
      end
      send_word(directed_rows[i].word, row_controls);
      if (i % 4 == 3) pause_input($urandom_range(1, 11));
    end
    gap_odds = 0;
    for (int i = DIRECTED_COUNT; i < WORD_COUNT; i++) begin
      logic [31:0] w;
      w = random_word();
      send_word(w, decode_controls(w));
      if (i % 100 == 0) gap_odds = $urandom_range(0, 3);
      if (i < WORD_COUNT - QUIET_TAIL && gap_odds != 0 &&
          $urandom_range(0, 3 * gap_odds) == 0) begin
        pause_input($urandom_range(1, 11));
      end
    end
    start <= 1'b0;
    while (pending_controls.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* rv64im_control_decoder.f */
hdl/rvdec_pkg.sv
hdl/rvdec_decode.sv
hdl/rv64im_control_decoder.sv
hdl/rvdec_checker.sv
dv/testbench.sv
